// ===== rtl/cvse_pkg.sv =====
`default_nettype none
package cvse_pkg;

   localparam int NoteWidth    = 7;
   localparam int SustainCount = 3;

   localparam logic [1:0] KindNone    = 2'd0;
   localparam logic [1:0] KindPress   = 2'd1;
   localparam logic [1:0] KindScan    = 2'd2;
   localparam logic [1:0] KindRelease = 2'd3;

   localparam logic [NoteWidth-1:0] StrumBase   = 7'd60;
   localparam logic [NoteWidth-1:0] StrumTop    = 7'd96;
   localparam logic [NoteWidth-1:0] StrumWrap   = 7'd36;
   localparam logic [NoteWidth-1:0] Octave      = 7'd12;
   localparam logic [NoteWidth-1:0] TwoOctaves  = 7'd24;
   localparam logic [NoteWidth-1:0] RootLow     = 7'd48;
   localparam logic [NoteWidth-1:0] RootHigh    = 7'd36;
   localparam logic [3:0]           MaxRaises   = 4'd8;
   localparam logic [3:0]           LastChord   = 4'd8;
   localparam logic [3:0]           FirstSeventh = 4'd4;

   typedef struct packed {
      logic init_voice;
      logic raise;
      logic store;
      logic adjust;
      logic sort_pass;
      logic parity;
      logic latch_item;
      logic emit;
      logic emit_strum;
      logic on_from_touch;
      logic on;
      logic last;
      logic last_from_scan;
   } cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic dup;
      logic four_tone;
      logic out_free;
      logic changed;
   } status_type;

   function automatic logic [3:0] chord_interval(input logic [3:0] kind, input logic [1:0] k);
      logic [15:0] row;
      begin
         case (kind)
            4'd1:    row = {4'd0, 4'd3, 4'd7, 4'd0};
            4'd2:    row = {4'd0, 4'd4, 4'd8, 4'd0};
            4'd3:    row = {4'd0, 4'd3, 4'd6, 4'd0};
            4'd4:    row = {4'd11, 4'd4, 4'd7, 4'd0};
            4'd5:    row = {4'd10, 4'd3, 4'd7, 4'd0};
            4'd6:    row = {4'd10, 4'd4, 4'd7, 4'd0};
            4'd7:    row = {4'd10, 4'd3, 4'd6, 4'd0};
            4'd8:    row = {4'd9, 4'd3, 4'd6, 4'd0};
            default: row = {4'd0, 4'd4, 4'd7, 4'd0};
         endcase
         return row[{k, 2'b00} +: 4];
      end
   endfunction

   function automatic logic [3:0] mod12(input logic [6:0] x);
      logic [12:0] prod;
      logic [3:0]  q;
      logic [6:0]  rem;
      begin
         prod = 13'(x) * 13'd43;
         q    = prod[12:9];
         rem  = x - ({q, 3'b000} + 7'({q, 2'b00}));
         if (rem >= 7'd12) begin
            rem = rem - 7'd12;
         end
         return rem[3:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cvse_ctrl.sv =====
`default_nettype none
module cvse_ctrl import cvse_pkg::*; #(
   parameter int StringCount = 8,
   parameter int IdxWidth    = 3
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_event_kind,
   input  wire status_type          status,
   output cmd_type                  cmd,
   output logic [IdxWidth-1:0]      idx,
   output logic [1:0]               tone
);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ADJ   = 3'd2;
   localparam logic [2:0] S_SORT  = 3'd3;
   localparam logic [2:0] S_IDLE  = 3'd4;
   localparam logic [2:0] S_SUS   = 3'd5;
   localparam logic [2:0] S_STRUM = 3'd6;
   localparam logic [2:0] S_SCAN  = 3'd7;

   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(StringCount - 1);
   localparam logic [IdxWidth-1:0] LastSus = IdxWidth'(SustainCount - 1);
   localparam logic [IdxWidth-1:0] IdxOne  = IdxWidth'(1);

   logic [2:0]          state_ff, state_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic [1:0]          tone_ff, tone_in;
   logic [3:0]          raise_ff, raise_in;
   logic [IdxWidth-1:0] pass_ff, pass_in;
   logic [1:0]          kind_ff, kind_in;
   logic [1:0]          tone_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff   <= '0;
         tone_ff  <= '0;
         raise_ff <= '0;
         pass_ff  <= '0;
         kind_ff  <= KindNone;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         tone_ff  <= tone_in;
         raise_ff <= raise_in;
         pass_ff  <= pass_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign idx       = idx_ff;
   assign tone_next = (tone_ff == (status.four_tone ? 2'd3 : 2'd2)) ? 2'd0 : tone_ff + 2'd1;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      tone_in  = tone_ff;
      raise_in = raise_ff;
      pass_in  = pass_ff;
      kind_in  = kind_ff;
      tone     = tone_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.init_voice = 1'b1;
            tone     = 2'd0;
            tone_in  = 2'd0;
            idx_in   = '0;
            raise_in = '0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.dup && raise_ff < MaxRaises) begin
               cmd.raise = 1'b1;
               raise_in  = raise_ff + 4'd1;
            end else begin
               cmd.store = 1'b1;
               tone      = tone_next;
               tone_in   = tone_next;
               raise_in  = '0;
               if (idx_ff == LastIdx) begin
                  state_in = S_ADJ;
               end else begin
                  idx_in = idx_ff + IdxOne;
               end
            end
         end
         S_ADJ: begin
            cmd.adjust = status.four_tone;
            pass_in    = '0;
            state_in   = S_SORT;
         end
         S_SORT: begin
            cmd.sort_pass = 1'b1;
            cmd.parity    = pass_ff[0];
            pass_in       = pass_ff + IdxOne;
            if (pass_ff == LastIdx) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            idx_in  = '0;
            kind_in = req_event_kind;
            if (req_valid) begin
               case (req_event_kind)
                  KindPress, KindRelease: state_in = S_SUS;
                  KindScan: begin
                     cmd.latch_item = 1'b1;
                     state_in       = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SUS: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.on   = (kind_ff == KindPress);
               cmd.last = (kind_ff == KindPress) && (idx_ff == LastSus);
               if (idx_ff == LastSus) begin
                  idx_in   = '0;
                  state_in = (kind_ff == KindPress) ? S_IDLE : S_STRUM;
               end else begin
                  idx_in = idx_ff + IdxOne;
               end
            end
         end
         S_STRUM: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_strum = 1'b1;
               cmd.last       = (idx_ff == LastIdx);
               if (idx_ff == LastIdx) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IdxOne;
               end
            end
         end
         S_SCAN: begin
            if (!status.changed || status.out_free) begin
               cmd.emit           = status.changed;
               cmd.emit_strum     = 1'b1;
               cmd.on_from_touch  = 1'b1;
               cmd.last_from_scan = 1'b1;
               if (idx_ff == LastIdx) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IdxOne;
               end
            end
         end
         default: state_in = S_INIT;
      endcase
      if (status.cfg_write) begin
         state_in = S_INIT;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cvse_dp.sv =====
`default_nettype none
module cvse_dp import cvse_pkg::*; #(
   parameter int StringCount = 8,
   parameter int IdxWidth    = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   input  wire logic [7:0]           req_touch_bits,
   input  wire cmd_type              cmd,
   input  wire logic [IdxWidth-1:0]  idx,
   input  wire logic [1:0]           tone,
   output status_type                status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_voice_index,
   output logic [6:0]                rsp_pitch,
   output logic                      rsp_note_on,
   output logic                      rsp_voice_group,
   output logic                      rsp_last
);

   logic [6:0] root_ff;
   logic [3:0] chord_ff;
   logic [NoteWidth-1:0] note_ff, note_in;
   logic [NoteWidth-1:0] strum_ff [StringCount];
   logic [NoteWidth-1:0] strum_in [StringCount];
   logic [NoteWidth-1:0] sustain_ff [SustainCount];
   logic [StringCount-1:0] prev_ff, touch_ff, mask_ff;
   logic [StringCount+7:0] touch_wide;
   logic [StringCount-1:0] touch_ext;
   logic       csr_write;
   logic [3:0] kind_eff;
   logic       four_tone;
   logic [3:0] root_pc;
   logic [NoteWidth-1:0] base;
   logic [4:0] start_sum;
   logic [NoteWidth-1:0] note_start;
   logic [NoteWidth-1:0] raised;
   logic       dup;
   logic       rsp_valid_ff;
   logic [2:0] rsp_voice_ff;
   logic [6:0] rsp_pitch_ff;
   logic       rsp_on_ff, rsp_group_ff, rsp_last_ff;
   logic       rest_empty;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? {28'd0, chord_ff} : {25'd0, root_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff  <= '0;
         chord_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2]) begin
            chord_ff <= csr_pwdata[3:0];
         end else begin
            root_ff <= csr_pwdata[6:0];
         end
      end
   end

   assign kind_eff   = (chord_ff <= LastChord) ? chord_ff : 4'd0;
   assign four_tone  = (kind_eff >= FirstSeventh);
   assign root_pc    = mod12(root_ff);
   assign base       = (root_pc < 4'd7) ? 7'(root_pc) + RootLow : 7'(root_pc) + RootHigh;

   always_comb begin
      start_sum = 5'(root_pc) + 5'(chord_interval(kind_eff, tone));
      if (start_sum >= 5'd12) begin
         start_sum = start_sum - 5'd12;
      end
      note_start = StrumBase + 7'(start_sum);
      raised = note_ff + Octave;
      if (raised > StrumTop) begin
         raised = raised - StrumWrap;
      end
      dup = 1'b0;
      for (int j = 0; j < StringCount; j++) begin
         if (j < int'(idx) && strum_ff[j] == note_ff) begin
            dup = 1'b1;
         end
      end
   end

   always_comb begin
      note_in = note_ff;
      if (cmd.init_voice || cmd.store) begin
         note_in = note_start;
      end else if (cmd.raise) begin
         note_in = raised;
      end
   end

   always_comb begin
      for (int k = 0; k < StringCount; k++) begin
         strum_in[k] = strum_ff[k];
      end
      if (cmd.store) begin
         strum_in[idx] = note_ff;
      end
      if (cmd.adjust) begin
         strum_in[1] = strum_ff[1] + TwoOctaves;
         strum_in[2] = strum_ff[2] + TwoOctaves;
      end
      if (cmd.sort_pass) begin
         for (int k = 0; k < StringCount - 1; k++) begin
            if ((k % 2) == int'(cmd.parity) && strum_ff[k] < strum_ff[k+1]) begin
               strum_in[k]   = strum_ff[k+1];
               strum_in[k+1] = strum_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
      for (int k = 0; k < StringCount; k++) begin
         strum_ff[k] <= strum_in[k];
      end
      if (cmd.init_voice) begin
         sustain_ff[0] <= base + 7'(chord_interval(kind_eff, 2'd0));
         sustain_ff[1] <= base + 7'(chord_interval(kind_eff, four_tone ? 2'd3 : 2'd1));
         sustain_ff[2] <= base + 7'(chord_interval(kind_eff, 2'd2)) + Octave;
      end
   end

   assign touch_wide = {StringCount'(0), req_touch_bits};
   assign touch_ext  = touch_wide[StringCount-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (cmd.latch_item) begin
         prev_ff <= touch_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         touch_ff <= touch_ext;
         mask_ff  <= touch_ext ^ prev_ff;
      end
   end

   assign rest_empty = ((mask_ff >> idx) >> 1) == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_voice_ff <= 3'(idx);
         rsp_pitch_ff <= cmd.emit_strum ? strum_ff[idx] : sustain_ff[idx[1:0]];
         rsp_on_ff    <= cmd.on_from_touch ? touch_ff[idx] : cmd.on;
         rsp_group_ff <= cmd.emit_strum;
         rsp_last_ff  <= cmd.last_from_scan ? rest_empty : cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_voice_index = rsp_voice_ff;
   assign rsp_pitch       = rsp_pitch_ff;
   assign rsp_note_on     = rsp_on_ff;
   assign rsp_voice_group = rsp_group_ff;
   assign rsp_last        = rsp_last_ff;

   assign status.cfg_write = csr_write;
   assign status.dup       = dup;
   assign status.four_tone = four_tone;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.changed   = mask_ff[idx];

endmodule
`default_nettype wire

// ===== rtl/chord_voicing_strum_events.sv =====
// Chord note generator for a strummed instrument.
// Configuration is an APB-style port with pready tied high: root_note at byte
// address 0 and chord_type at byte address 4. Each write rebuilds the voicing.
// The input channel takes one event beat: none, chord press, touch scan or
// chord release. The result channel returns one note event per beat, with
// last marking the final beat caused by an input.
// A press returns three beats, a release three plus STRING_COUNT beats, and
// a scan one beat per changed plate; none and an unchanged scan return none.
// Results are produced one per cycle from a single output register while
// the receiver does not stall; a new input beat is taken only once every
// result of the previous one has been issued, and each input beat loads the
// sequencer state register, which then loads the output register.
// After reset and after any register write the voicing builder runs before
// req_ready rises: it places each plate in turn, with at most eight octave
// raises per plate, then runs STRING_COUNT passes of an odd-even sort.
// When the receiver stalls, the event sequencer holds until the output
// register is taken; no result is dropped.
`default_nettype none
module chord_voicing_strum_events import cvse_pkg::*; #(
   parameter int STRING_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_event_kind,
   input  wire logic [7:0]  req_touch_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_voice_index,
   output logic [6:0]       rsp_pitch,
   output logic             rsp_note_on,
   output logic             rsp_voice_group,
   output logic             rsp_last
);

   localparam int IdxWidth = $clog2(STRING_COUNT);

   cmd_type             cmd;
   status_type          status;
   logic [IdxWidth-1:0] idx;
   logic [1:0]          tone;

   assign csr_pready = 1'b1;

   cvse_ctrl #(
      .StringCount(STRING_COUNT),
      .IdxWidth   (IdxWidth)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_event_kind(req_event_kind),
      .status        (status),
      .cmd           (cmd),
      .idx           (idx),
      .tone          (tone)
   );

   cvse_dp #(
      .StringCount(STRING_COUNT),
      .IdxWidth   (IdxWidth)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .req_touch_bits (req_touch_bits),
      .cmd            (cmd),
      .idx            (idx),
      .tone           (tone),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_voice_index(rsp_voice_index),
      .rsp_pitch      (rsp_pitch),
      .rsp_note_on    (rsp_note_on),
      .rsp_voice_group(rsp_voice_group),
      .rsp_last       (rsp_last)
   );

   a_cfg_rebuild: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite) |=> !req_ready)
      else $error("register write did not start a voicing rebuild");

   a_none_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_event_kind == KindNone) |=> req_ready)
      else $error("empty event left the block busy");

   a_press_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_event_kind == KindPress) |=> !req_ready)
      else $error("press accepted without emitting its events");

endmodule
`default_nettype wire

// ===== verif/chord_event_checker.sv =====
module chord_event_checker import cvse_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       cfg_write,
   input  wire logic [2:0] cfg_addr,
   input  wire logic [31:0] cfg_data,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [1:0] req_event_kind,
   input  wire logic [7:0] req_touch_bits,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [2:0] rsp_voice_index,
   input  wire logic [6:0] rsp_pitch,
   input  wire logic       rsp_note_on,
   input  wire logic       rsp_voice_group,
   input  wire logic       rsp_last,
   output int              fail_count,
   output int              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0] voice;
      logic [6:0] pitch;
      logic       on;
      logic       group;
      logic       last;
   } note_event_type;

   note_event_type note_events_due[$];
   logic [6:0] root_reg;
   logic [3:0] chord_reg;
   int strum_notes[8];
   int sustain_notes[3];
   logic [7:0] touch_prev;

   function automatic int tone_step(input logic [3:0] ct, input int k);
      int rows[9][4] = '{'{0, 7, 4, 0}, '{0, 7, 3, 0}, '{0, 8, 4, 0}, '{0, 6, 3, 0},
                         '{0, 7, 4, 11}, '{0, 7, 3, 10}, '{0, 7, 4, 10},
                         '{0, 6, 3, 10}, '{0, 6, 3, 9}};
      int t;
      t = (ct <= 4'd8) ? int'(ct) : 0;
      return rows[t][k];
   endfunction

   task automatic voice_chord();
      int r, base, t, tones, note, v, j;
      int p[4];
      bit dup;
      r = int'(root_reg) % 12;
      base = (r < 7) ? r + 48 : r + 36;
      t = (chord_reg <= 4'd8) ? int'(chord_reg) : 0;
      tones = (t >= 4) ? 4 : 3;
      for (int k = 0; k < 4; k++) p[k] = base + tone_step(chord_reg, k);
      for (int i = 0; i < 8; i++) begin
         note = 60 + p[i % tones] % 12;
         for (int k = 0; k < 8; k++) begin
            dup = 0;
            for (j = 0; j < i; j++) if (strum_notes[j] == note) dup = 1;
            if (!dup) break;
            note += 12;
            if (note > 96) note -= 36;
         end
         strum_notes[i] = note;
      end
      sustain_notes[0] = p[0];
      sustain_notes[2] = p[2] + 12;
      if (tones == 3) begin
         sustain_notes[1] = p[1];
      end else begin
         sustain_notes[1] = p[3];
         strum_notes[1] += 24;
         strum_notes[2] += 24;
      end
      for (int i = 1; i < 8; i++) begin
         v = strum_notes[i];
         j = i;
         while (j > 0 && strum_notes[j-1] < v) begin
            strum_notes[j] = strum_notes[j-1];
            j--;
         end
         strum_notes[j] = v;
      end
   endtask

   task automatic push_note(input int voice, input int pitch, input bit on, input bit group);
      note_event_type e;
      e.voice = voice[2:0];
      e.pitch = pitch[6:0];
      e.on = on;
      e.group = group;
      e.last = 0;
      note_events_due = {note_events_due, e};
   endtask

   task automatic predict_event(input logic [1:0] kind, input logic [7:0] touch);
      int before_n;
      before_n = note_events_due.size();
      if (kind == KindPress) begin
         for (int i = 0; i < 3; i++) push_note(i, sustain_notes[i], 1, 0);
      end else if (kind == KindScan) begin
         for (int i = 0; i < 8; i++) begin
            if (touch[i] && !touch_prev[i]) push_note(i, strum_notes[i], 1, 1);
            else if (!touch[i] && touch_prev[i]) push_note(i, strum_notes[i], 0, 1);
         end
         touch_prev = touch;
      end else if (kind == KindRelease) begin
         for (int i = 0; i < 3; i++) push_note(i, sustain_notes[i], 0, 0);
         for (int i = 0; i < 8; i++) push_note(i, strum_notes[i], 0, 1);
      end
      if (note_events_due.size() > before_n)
         note_events_due[note_events_due.size()-1].last = 1;
   endtask

   always @(posedge clock) begin
      note_event_type want;
      if (reset) begin
         touch_prev = '0;
         note_events_due.delete();
         fail_count <= 0;
         root_reg = '0;
         chord_reg = '0;
         voice_chord();
      end else begin
         if (cfg_write) begin
            if (cfg_addr == 3'd0) begin
               root_reg = cfg_data[6:0];
               voice_chord();
            end else if (cfg_addr == 3'd4) begin
               chord_reg = cfg_data[3:0];
               voice_chord();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (note_events_due.size() == 0) begin
               $display("%t: unexpected beat voice=%0d pitch=%0d on=%0d group=%0d last=%0d",
                        $realtime, rsp_voice_index, rsp_pitch, rsp_note_on,
                        rsp_voice_group, rsp_last);
               fail_count <= fail_count + 1;
            end else begin
               want = note_events_due.pop_front();
               if (want !== {rsp_voice_index, rsp_pitch, rsp_note_on, rsp_voice_group,
                             rsp_last}) begin
                  $display("%t: expected voice=%0d pitch=%0d on=%0d group=%0d last=%0d,",
                           $realtime, want.voice, want.pitch, want.on, want.group, want.last);
                  $display("   actual voice=%0d pitch=%0d on=%0d group=%0d last=%0d",
                           rsp_voice_index, rsp_pitch, rsp_note_on, rsp_voice_group,
                           rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_event(req_event_kind, req_touch_bits);
      end
      pending_count <= note_events_due.size();
   end
endmodule

// ===== verif/tb_chord_voicing_strum_events.sv =====
module tb_chord_voicing_strum_events import cvse_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   logic req_valid = 0, req_ready;
   logic [1:0] req_event_kind = KindNone;
   logic [7:0] req_touch_bits = '0;
   logic rsp_valid, rsp_ready = 0;
   logic [2:0] rsp_voice_index;
   logic [6:0] rsp_pitch;
   logic rsp_note_on, rsp_voice_group, rsp_last;
   int fail_count, pending_count;
   int idle_cycles = 0;
   int hold_left = 0;
   bit long_hold = 0;
   bit stall_mode = 0;

   localparam logic [2:0] AddrRoot  = 3'd0;
   localparam logic [2:0] AddrChord = 3'd4;
   localparam int IdleLimit = 4000;
   localparam int HoldCycles = 150;

   chord_voicing_strum_events dut (.*);

   chord_event_checker checker_i (
      .clock, .reset,
      .cfg_write(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_addr(csr_paddr), .cfg_data(csr_pwdata),
      .req_valid, .req_ready, .req_event_kind, .req_touch_bits,
      .rsp_valid, .rsp_ready, .rsp_voice_index, .rsp_pitch, .rsp_note_on,
      .rsp_voice_group, .rsp_last, .fail_count, .pending_count);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (long_hold) begin
         rsp_ready <= 0;
         hold_left <= HoldCycles;
      end else if (hold_left > 0) begin
         rsp_ready <= 0;
         hold_left <= hold_left - 1;
      end else if (stall_mode) rsp_ready <= ($urandom_range(0, 3) == 0);
      else rsp_ready <= ($urandom_range(0, 4) != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_event(input logic [1:0] kind, input logic [7:0] touch);
      req_valid <= 1;
      req_event_kind <= kind;
      req_touch_bits <= touch;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic random_burst(input int count);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst = $urandom_range(1, 12);
         end
         case ($urandom_range(0, 9))
            0: send_event(KindNone, 8'($urandom));
            1, 2: send_event(KindPress, 8'($urandom));
            3: send_event(KindRelease, 8'($urandom));
            default: send_event(KindScan, 8'($urandom));
         endcase
         burst--;
      end
   endtask

   initial begin
      logic [7:0] walk;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_event(KindPress, 8'h00);
      send_event(KindScan, 8'hFF);
      send_event(KindScan, 8'hFF);
      send_event(KindScan, 8'h00);
      send_event(KindScan, 8'hA5);
      send_event(KindRelease, 8'h5A);
      send_event(KindScan, 8'h5A);
      send_event(KindNone, 8'hFF);
      walk = 8'h01;
      for (int i = 0; i < 8; i++) begin
         send_event(KindScan, walk);
         walk = walk << 1;
      end
      send_event(KindScan, 8'h00);
      drain();
      for (int c = 0; c < 16; c++) begin
         write_reg(AddrChord, 32'(c));
         write_reg(AddrRoot, 32'($urandom_range(0, 127)));
         send_event(KindPress, 8'h00);
         send_event(KindRelease, 8'h00);
         send_event(KindScan, 8'($urandom));
         drain();
      end
      write_reg(AddrRoot, 32'd127);
      write_reg(AddrChord, 32'd8);
      send_event(KindRelease, 8'h00);
      send_event(KindScan, 8'hFF);
      drain();
      write_reg(AddrRoot, 32'hFFFF_FF80);
      write_reg(AddrChord, 32'hFFFF_FFF4);
      send_event(KindPress, 8'h00);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         write_reg(AddrRoot, 32'($urandom_range(0, 127)));
         write_reg(AddrChord, 32'($urandom_range(0, 15)));
         stall_mode <= phase[0];
         random_burst(32);
         if (phase == 2) begin
            req_valid <= 0;
            long_hold <= 1;
            @(posedge clock);
            long_hold <= 0;
            for (int i = 0; i < 10; i++) send_event(KindRelease, 8'($urandom));
         end
         drain();
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
